// File: hw/rtl/rth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_pkg
// Shared widths, constants and stage payload types for the RGB to HSV block.
// ----------------------------------------------------------------------------
package rth_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int CHAN_W        = 8;
    localparam int HUE_W         = 16;
    localparam int SAT_W         = 16;
    localparam int SEXT_W        = CHAN_W + 3;
    localparam int NSTEPS        = (FRACTION_BITS > SAT_W) ? FRACTION_BITS : SAT_W;
    localparam int HUE_START     = NSTEPS - FRACTION_BITS;
    localparam int SAT_START     = NSTEPS - SAT_W;

    typedef struct packed {
        logic [SEXT_W-1:0]        hue_rem;
        logic [SEXT_W-1:0]        hue_div;
        logic [FRACTION_BITS-1:0] hue_q;
        logic [CHAN_W-1:0]        sat_rem;
        logic [SAT_W-1:0]         sat_num;
        logic [CHAN_W-1:0]        sat_div;
        logic [SAT_W-1:0]         sat_q;
        logic [CHAN_W-1:0]        val;
    } t_pix;

    typedef struct packed {
        logic hue_en;
        logic sat_en;
    } t_step_ctl;

endpackage

// File: hw/rtl/rgb_to_hsv_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_top
// Pipelined RGB to HSV conversion, one pixel per clock while the receiver takes pixels.
//
// Input channel: i_valid / o_ready with i_red_in, i_green_in, i_blue_in.
// Output channel: o_valid / i_ready with o_hue_out, o_sat_out, o_val_out.
// Each item passes one set-up stage (max, min, delta, sextant numerator)
// and then NSTEPS restoring division stages, one quotient bit per stage
// for hue and saturation side by side; NSTEPS is the larger of the hue
// fraction width and 16.
// Throughput is one item per cycle while the receiver takes items.
// The last division stage is the output register.
// Reset clears every stage valid bit; no item is in flight afterwards.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and o_ready falls; empty stages do not close up.
// ----------------------------------------------------------------------------
module rgb_to_hsv_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rth_pkg::CHAN_W-1:0] i_red_in,
    input  logic [rth_pkg::CHAN_W-1:0] i_green_in,
    input  logic [rth_pkg::CHAN_W-1:0] i_blue_in,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rth_pkg::HUE_W-1:0]  o_hue_out,
    output logic [rth_pkg::SAT_W-1:0]  o_sat_out,
    output logic [rth_pkg::CHAN_W-1:0] o_val_out
);
    import rth_pkg::*;

    logic             en;
    logic [NSTEPS:0]  stg_valid;
    t_pix             stg_pix [NSTEPS+1];

    assign en      = !stg_valid[NSTEPS] || i_ready;
    assign o_ready = en;

    rth_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_valid (stg_valid[0]),
        .o_pix   (stg_pix[0])
    );

    for (genvar k = 0; k < NSTEPS; k++) begin : g_step
        t_step_ctl ctl;
        assign ctl.hue_en = (k >= HUE_START);
        assign ctl.sat_en = (k >= SAT_START);

        rth_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl),
            .i_valid (stg_valid[k]),
            .i_pix   (stg_pix[k]),
            .o_valid (stg_valid[k+1]),
            .o_pix   (stg_pix[k+1])
        );
    end

    if (FRACTION_BITS >= HUE_W) begin : g_hue_wide
        assign o_hue_out = stg_pix[NSTEPS].hue_q[HUE_W-1:0];
    end else begin : g_hue_narrow
        assign o_hue_out = {{(HUE_W-FRACTION_BITS){1'b0}}, stg_pix[NSTEPS].hue_q};
    end

    assign o_valid   = stg_valid[NSTEPS];
    assign o_sat_out = stg_pix[NSTEPS].sat_q;
    assign o_val_out = stg_pix[NSTEPS].val;

endmodule

// File: hw/rtl/rth_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_front
// First stage: max, min, delta, hue sextant numerator and divider set-up.
// ----------------------------------------------------------------------------
module rth_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [rth_pkg::CHAN_W-1:0] i_red,
    input  logic [rth_pkg::CHAN_W-1:0] i_green,
    input  logic [rth_pkg::CHAN_W-1:0] i_blue,
    output logic                       o_valid,
    output rth_pkg::t_pix              o_pix
);
    import rth_pkg::*;

    logic                  r_valid;
    t_pix                  r_pix;
    t_pix                  n_pix;
    logic [CHAN_W-1:0]     mx;
    logic [CHAN_W-1:0]     mn;
    logic [CHAN_W-1:0]     delta;
    logic [SEXT_W-1:0]     d6;
    logic [SEXT_W-1:0]     num;
    logic [CHAN_W+SAT_W-1:0] sat_n;

    always_comb begin
        mx = (i_red > i_green) ? i_red : i_green;
        mx = (mx > i_blue) ? mx : i_blue;
        mn = (i_red < i_green) ? i_red : i_green;
        mn = (mn < i_blue) ? mn : i_blue;
        delta = mx - mn;
        d6 = ({3'b000, delta} << 2) + ({3'b000, delta} << 1);
        priority if (mx == i_red) begin
            if (i_green >= i_blue) begin
                num = {3'b000, i_green} - {3'b000, i_blue};
            end else begin
                num = d6 - ({3'b000, i_blue} - {3'b000, i_green});
            end
        end else if (mx == i_green) begin
            num = ({3'b000, delta} << 1) + {3'b000, i_blue} - {3'b000, i_red};
        end else begin
            num = ({3'b000, delta} << 2) + {3'b000, i_red} - {3'b000, i_green};
        end
        sat_n = {delta, {SAT_W{1'b0}}} - {{SAT_W{1'b0}}, delta};

        n_pix.hue_rem = num;
        n_pix.hue_div = (delta == '0) ? SEXT_W'(1) : d6;
        n_pix.hue_q   = '0;
        n_pix.sat_rem = sat_n[CHAN_W+SAT_W-1:SAT_W];
        n_pix.sat_num = sat_n[SAT_W-1:0];
        n_pix.sat_div = (mx == '0) ? CHAN_W'(1) : mx;
        n_pix.sat_q   = '0;
        n_pix.val     = mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

// File: hw/rtl/rth_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_div_step
// One restoring division step for hue and saturation, one quotient bit each when enabled.
// ----------------------------------------------------------------------------
module rth_div_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  rth_pkg::t_step_ctl i_ctl,
    input  logic               i_valid,
    input  rth_pkg::t_pix      i_pix,
    output logic               o_valid,
    output rth_pkg::t_pix      o_pix
);
    import rth_pkg::*;

    logic              r_valid;
    t_pix              r_pix;
    t_pix              n_pix;
    logic [SEXT_W:0]   hue_t;
    logic              hue_ge;
    logic [CHAN_W:0]   sat_t;
    logic              sat_ge;

    always_comb begin
        n_pix  = i_pix;
        hue_t  = {i_pix.hue_rem, 1'b0};
        hue_ge = hue_t >= {1'b0, i_pix.hue_div};
        sat_t  = {i_pix.sat_rem, i_pix.sat_num[SAT_W-1]};
        sat_ge = sat_t >= {1'b0, i_pix.sat_div};
        if (i_ctl.hue_en) begin
            n_pix.hue_rem = hue_ge ? SEXT_W'(hue_t - {1'b0, i_pix.hue_div})
                                   : hue_t[SEXT_W-1:0];
            n_pix.hue_q   = {i_pix.hue_q[FRACTION_BITS-2:0], hue_ge};
        end
        if (i_ctl.sat_en) begin
            n_pix.sat_rem = sat_ge ? CHAN_W'(sat_t - {1'b0, i_pix.sat_div})
                                   : sat_t[CHAN_W-1:0];
            n_pix.sat_num = {i_pix.sat_num[SAT_W-2:0], 1'b0};
            n_pix.sat_q   = {i_pix.sat_q[SAT_W-2:0], sat_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

// File: hw/rtl/rth_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_checker
// Port-level checks on the RGB to HSV block, bound to the top level.
// ----------------------------------------------------------------------------
module rth_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [rth_pkg::HUE_W-1:0]  o_hue_out,
    input logic [rth_pkg::SAT_W-1:0]  o_sat_out,
    input logic [rth_pkg::CHAN_W-1:0] o_val_out
);
    import rth_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("item shown straight after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hue_out)
                                && $stable(o_sat_out) && $stable(o_val_out))
        else $error("stalled item dropped or changed");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_val_out == '0 |-> o_sat_out == '0 && o_hue_out == '0)
        else $error("black pixel with hue or saturation");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sat_out == '0 |-> o_hue_out == '0)
        else $error("grey pixel with hue");

endmodule

bind rgb_to_hsv_top rth_checker u_rth_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_hue_out (o_hue_out),
    .o_sat_out (o_sat_out),
    .o_val_out (o_val_out)
);
